@@ sv/fr_pkg.sv @@
package fr_pkg;

    // vector fraction bits of the direction and normal components
    localparam int VEC_FRAC_BITS = 14;

    // cosine conversion from the dot product scale to Q.30
    localparam int DOT_SHIFT = 2 * VEC_FRAC_BITS - 30;
    localparam int DOT_SH_R  = (DOT_SHIFT >= 0) ? DOT_SHIFT : 0;
    localparam int DOT_SH_L  = (DOT_SHIFT < 0) ? -DOT_SHIFT : 0;
    localparam logic [63:0] ONE_DOT = 64'd1 << (2 * VEC_FRAC_BITS);

    localparam logic [63:0] ONE_Q30  = 64'd1 << 30;
    localparam logic [31:0] ONE_Q31  = 32'h8000_0000;
    localparam logic [15:0] REFL_ONE = 16'd32768;
    localparam logic [15:0] CFG_RESET_INDEX = 16'd4096;

    // iterative units, steps done per pipeline stage
    localparam int SQRT_STEPS  = 4;
    localparam int SQRT_STAGES = 32 / SQRT_STEPS;
    localparam int DIV_STEPS   = 4;
    localparam int DIV_STAGES  = 32 / DIV_STEPS;

    // pipeline stage map
    localparam int ST_PROD    = 0;
    localparam int ST_DOT     = ST_PROD + 1;
    localparam int ST_COS     = ST_DOT + 1;
    localparam int ST_CSQ     = ST_COS + 1;
    localparam int ST_SQ1     = ST_CSQ + 1;
    localparam int ST_SNELL   = ST_SQ1 + SQRT_STAGES + 1;
    localparam int ST_TIR     = ST_SNELL + 1;
    localparam int ST_TSQ     = ST_TIR + DIV_STAGES + 1;
    localparam int ST_SQ2     = ST_TSQ + 1;
    localparam int ST_MUL     = ST_SQ2 + SQRT_STAGES + 1;
    localparam int ST_SUM     = ST_MUL + 1;
    localparam int ST_NORM    = ST_SUM + 1;
    localparam int ST_RINIT   = ST_NORM + 1;
    localparam int ST_RSQ     = ST_RINIT + DIV_STAGES + 1;
    localparam int ST_OUT     = ST_RSQ + 1;
    localparam int NUM_STAGES = ST_OUT + 1;

    typedef struct packed {
        logic [63:0] rad;
        logic [34:0] rem;
        logic [31:0] root;
    } sq_t;

    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] feed;
        logic [31:0] quo;
        logic [31:0] den;
    } dv_t;

    typedef struct packed {
        logic [15:0]        etai;
        logic [15:0]        etat;
        logic signed [31:0] p0;
        logic signed [31:0] p1;
        logic signed [31:0] p2;
        logic signed [33:0] dot;
        logic [30:0]        ci;
        logic [61:0]        sqr;
        sq_t                sq;
        logic [47:0]        ma;
        logic [47:0]        mb;
        logic [47:0]        mc;
        logic [47:0]        md;
        logic               tir;
        dv_t                dv_s;
        dv_t                dv_p;
        logic [47:0]        ns;
        logic [47:0]        ds;
        logic [47:0]        np;
        logic [47:0]        dp;
        logic [31:0]        ns_n;
        logic [31:0]        ds_n;
        logic [31:0]        np_n;
        logic [31:0]        dp_n;
        logic               zs;
        logic               zp;
        logic [63:0]        rs2;
        logic [63:0]        rp2;
        logic [15:0]        refl;
    } ctx_t;

endpackage

@@ sv/fresnel_reflectance.sv @@
// channel   direction  handshake               word
// cfg       in         cfg_valid / cfg_ready   cfg_data (outer medium index, Q4.12)
// in        in         in_valid / in_ready     dir_*, normal_*, object_index
// out       out        out_valid / out_ready   reflectance (Q1.15), total_internal
//
// fixed pipeline of NUM_STAGES (47) register stages, one word accepted per cycle while the output is not stalled
// latency is set by the two 32-step square roots and two 32-step divider sections, 4 steps a stage
// rst_n clears the valid bits and loads the outer index with 1.0; no clearing pass
// a stalled output freezes the whole pipeline and holds off input, bubbles included
// cfg_ready is always high; config writes are to be made only while idle, the block does not enforce it
module fresnel_reflectance
    import fr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] dir_x,
    input  logic signed [15:0] dir_y,
    input  logic signed [15:0] dir_z,
    input  logic signed [15:0] normal_x,
    input  logic signed [15:0] normal_y,
    input  logic signed [15:0] normal_z,
    input  logic [15:0]        object_index,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [15:0]        reflectance,
    output logic               total_internal
);

    logic [15:0]           outer_index_reg;
    logic [NUM_STAGES-1:0] valid_reg;
    ctx_t                  ctx_reg  [NUM_STAGES];
    ctx_t                  ctx_next [NUM_STAGES];
    logic                  adv;

    // whole pipeline moves when the output slot is free or being taken
    assign adv       = !valid_reg[ST_OUT] || out_ready;
    assign in_ready  = adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outer_index_reg <= CFG_RESET_INDEX;
        end
        else if (cfg_valid)
        begin
            outer_index_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[NUM_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < NUM_STAGES; i++)
            begin
                ctx_reg[i] <= ctx_next[i];
            end
        end
    end

    genvar k;
    generate
        for (k = 0; k < NUM_STAGES; k++)
        begin : g_stage
            if (k == ST_PROD)
            begin : g_prod
                // three component products, indices captured with the word
                always_comb
                begin
                    ctx_next[k]      = '0;
                    ctx_next[k].etai = outer_index_reg;
                    ctx_next[k].etat = object_index;
                    ctx_next[k].p0   = dir_x * normal_x;
                    ctx_next[k].p1   = dir_y * normal_y;
                    ctx_next[k].p2   = dir_z * normal_z;
                end
            end
            else if (k == ST_DOT)
            begin : g_dot
                always_comb
                begin
                    ctx_next[k]     = ctx_reg[k-1];
                    ctx_next[k].dot = 34'(ctx_reg[k-1].p0) + 34'(ctx_reg[k-1].p1)
                                    + 34'(ctx_reg[k-1].p2);
                end
            end
            else if (k == ST_COS)
            begin : g_cos
                // clamp |dot| to 1.0, rescale to Q.30, swap indices on the back side
                always_comb
                begin
                    logic [33:0] mag;
                    logic [63:0] m64;
                    logic [63:0] c64;
                    ctx_next[k] = ctx_reg[k-1];
                    mag = ctx_reg[k-1].dot[33] ? 34'(-ctx_reg[k-1].dot)
                                               : 34'(ctx_reg[k-1].dot);
                    m64 = {30'b0, mag};
                    if (m64 > ONE_DOT)
                    begin
                        m64 = ONE_DOT;
                    end
                    c64 = (m64 >> DOT_SH_R) << DOT_SH_L;
                    if (c64 > ONE_Q30)
                    begin
                        c64 = ONE_Q30;
                    end
                    ctx_next[k].ci = c64[30:0];
                    if (!ctx_reg[k-1].dot[33] && ctx_reg[k-1].dot != '0)
                    begin
                        ctx_next[k].etai = ctx_reg[k-1].etat;
                        ctx_next[k].etat = ctx_reg[k-1].etai;
                    end
                end
            end
            else if (k == ST_CSQ)
            begin : g_csq
                always_comb
                begin
                    ctx_next[k]     = ctx_reg[k-1];
                    ctx_next[k].sqr = ctx_reg[k-1].ci * ctx_reg[k-1].ci;
                end
            end
            else if (k == ST_SQ1 || k == ST_SQ2)
            begin : g_sqinit
                // radicand (1 - x^2) << 30
                always_comb
                begin
                    logic [33:0] diff;
                    ctx_next[k] = ctx_reg[k-1];
                    diff = 34'(ONE_Q30) - {2'b0, ctx_reg[k-1].sqr[61:30]};
                    ctx_next[k].sq.rad  = {diff, 30'b0};
                    ctx_next[k].sq.rem  = '0;
                    ctx_next[k].sq.root = '0;
                end
            end
            else if ((k > ST_SQ1 && k <= ST_SQ1 + SQRT_STAGES) ||
                     (k > ST_SQ2 && k <= ST_SQ2 + SQRT_STAGES))
            begin : g_sqrt
                sq_t sq_o;
                fr_sqrt_step u_sqrt (
                    .sq_in  (ctx_reg[k-1].sq),
                    .sq_out (sq_o)
                );
                always_comb
                begin
                    ctx_next[k]    = ctx_reg[k-1];
                    ctx_next[k].sq = sq_o;
                end
            end
            else if (k == ST_SNELL)
            begin : g_snell
                always_comb
                begin
                    ctx_next[k]    = ctx_reg[k-1];
                    ctx_next[k].ma = ctx_reg[k-1].etai * ctx_reg[k-1].sq.root;
                end
            end
            else if (k == ST_TIR)
            begin : g_tir
                // total internal reflection test, then set up sin_t division
                always_comb
                begin
                    ctx_next[k]          = ctx_reg[k-1];
                    ctx_next[k].tir      = ctx_reg[k-1].ma >=
                                           {2'b0, ctx_reg[k-1].etat, 30'b0};
                    ctx_next[k].dv_s.rem  = {16'b0, ctx_reg[k-1].ma[47:32]};
                    ctx_next[k].dv_s.feed = ctx_reg[k-1].ma[31:0];
                    ctx_next[k].dv_s.quo  = '0;
                    ctx_next[k].dv_s.den  = {16'b0, ctx_reg[k-1].etat};
                end
            end
            else if (k > ST_TIR && k <= ST_TIR + DIV_STAGES)
            begin : g_sdiv
                dv_t dv_o;
                fr_div_step u_div (
                    .dv_in  (ctx_reg[k-1].dv_s),
                    .dv_out (dv_o)
                );
                always_comb
                begin
                    ctx_next[k]      = ctx_reg[k-1];
                    ctx_next[k].dv_s = dv_o;
                end
            end
            else if (k == ST_TSQ)
            begin : g_tsq
                always_comb
                begin
                    ctx_next[k]     = ctx_reg[k-1];
                    ctx_next[k].sqr = ctx_reg[k-1].dv_s.quo[30:0]
                                    * ctx_reg[k-1].dv_s.quo[30:0];
                end
            end
            else if (k == ST_MUL)
            begin : g_mul
                // cross products for the s and p coefficients
                always_comb
                begin
                    ctx_next[k]    = ctx_reg[k-1];
                    ctx_next[k].ma = ctx_reg[k-1].etat * ctx_reg[k-1].ci;
                    ctx_next[k].mb = ctx_reg[k-1].etai * ctx_reg[k-1].sq.root[30:0];
                    ctx_next[k].mc = ctx_reg[k-1].etai * ctx_reg[k-1].ci;
                    ctx_next[k].md = ctx_reg[k-1].etat * ctx_reg[k-1].sq.root[30:0];
                end
            end
            else if (k == ST_SUM)
            begin : g_sum
                always_comb
                begin
                    ctx_next[k]    = ctx_reg[k-1];
                    ctx_next[k].ns = (ctx_reg[k-1].ma > ctx_reg[k-1].mb)
                                   ? ctx_reg[k-1].ma - ctx_reg[k-1].mb
                                   : ctx_reg[k-1].mb - ctx_reg[k-1].ma;
                    ctx_next[k].ds = ctx_reg[k-1].ma + ctx_reg[k-1].mb;
                    ctx_next[k].np = (ctx_reg[k-1].mc > ctx_reg[k-1].md)
                                   ? ctx_reg[k-1].mc - ctx_reg[k-1].md
                                   : ctx_reg[k-1].md - ctx_reg[k-1].mc;
                    ctx_next[k].dp = ctx_reg[k-1].mc + ctx_reg[k-1].md;
                end
            end
            else if (k == ST_NORM)
            begin : g_norm
                logic [31:0] ns_o;
                logic [31:0] ds_o;
                logic [31:0] np_o;
                logic [31:0] dp_o;
                fr_norm u_norm_s (
                    .num_in  (ctx_reg[k-1].ns),
                    .den_in  (ctx_reg[k-1].ds),
                    .num_out (ns_o),
                    .den_out (ds_o)
                );
                fr_norm u_norm_p (
                    .num_in  (ctx_reg[k-1].np),
                    .den_in  (ctx_reg[k-1].dp),
                    .num_out (np_o),
                    .den_out (dp_o)
                );
                always_comb
                begin
                    ctx_next[k]      = ctx_reg[k-1];
                    ctx_next[k].ns_n = ns_o;
                    ctx_next[k].ds_n = ds_o;
                    ctx_next[k].np_n = np_o;
                    ctx_next[k].dp_n = dp_o;
                end
            end
            else if (k == ST_RINIT)
            begin : g_rinit
                // numerator clamped to the denominator, dividend is num << 31
                always_comb
                begin
                    logic [31:0] n_s;
                    logic [31:0] n_p;
                    ctx_next[k]    = ctx_reg[k-1];
                    n_s = (ctx_reg[k-1].ns_n > ctx_reg[k-1].ds_n) ? ctx_reg[k-1].ds_n
                                                                  : ctx_reg[k-1].ns_n;
                    n_p = (ctx_reg[k-1].np_n > ctx_reg[k-1].dp_n) ? ctx_reg[k-1].dp_n
                                                                  : ctx_reg[k-1].np_n;
                    ctx_next[k].zs        = ctx_reg[k-1].ds_n == '0;
                    ctx_next[k].zp        = ctx_reg[k-1].dp_n == '0;
                    ctx_next[k].dv_s.rem  = {1'b0, n_s[31:1]};
                    ctx_next[k].dv_s.feed = {n_s[0], 31'b0};
                    ctx_next[k].dv_s.quo  = '0;
                    ctx_next[k].dv_s.den  = ctx_reg[k-1].ds_n;
                    ctx_next[k].dv_p.rem  = {1'b0, n_p[31:1]};
                    ctx_next[k].dv_p.feed = {n_p[0], 31'b0};
                    ctx_next[k].dv_p.quo  = '0;
                    ctx_next[k].dv_p.den  = ctx_reg[k-1].dp_n;
                end
            end
            else if (k > ST_RINIT && k <= ST_RINIT + DIV_STAGES)
            begin : g_rdiv
                dv_t dvs_o;
                dv_t dvp_o;
                fr_div_step u_div_s (
                    .dv_in  (ctx_reg[k-1].dv_s),
                    .dv_out (dvs_o)
                );
                fr_div_step u_div_p (
                    .dv_in  (ctx_reg[k-1].dv_p),
                    .dv_out (dvp_o)
                );
                always_comb
                begin
                    ctx_next[k]      = ctx_reg[k-1];
                    ctx_next[k].dv_s = dvs_o;
                    ctx_next[k].dv_p = dvp_o;
                end
            end
            else if (k == ST_RSQ)
            begin : g_rsq
                // a zero denominator counts as a coefficient of 1.0
                always_comb
                begin
                    logic [31:0] rs;
                    logic [31:0] rp;
                    ctx_next[k] = ctx_reg[k-1];
                    rs = ctx_reg[k-1].zs ? ONE_Q31 : ctx_reg[k-1].dv_s.quo;
                    rp = ctx_reg[k-1].zp ? ONE_Q31 : ctx_reg[k-1].dv_p.quo;
                    ctx_next[k].rs2 = rs * rs;
                    ctx_next[k].rp2 = rp * rp;
                end
            end
            else
            begin : g_out
                // mean of squares, round half up to Q1.15, saturate; a tir word gives 1.0
                always_comb
                begin
                    logic [32:0] sum;
                    logic [32:0] rnd;
                    logic [16:0] r;
                    ctx_next[k] = ctx_reg[k-1];
                    sum = {1'b0, ctx_reg[k-1].rs2[62:31]} + {1'b0, ctx_reg[k-1].rp2[62:31]};
                    rnd = {1'b0, sum[32:1]} + 33'h0_0000_8000;
                    r   = rnd[32:16];
                    if (ctx_reg[k-1].tir || r > {1'b0, REFL_ONE})
                    begin
                        ctx_next[k].refl = REFL_ONE;
                    end
                    else
                    begin
                        ctx_next[k].refl = r[15:0];
                    end
                end
            end
        end
    endgenerate

    assign out_valid      = valid_reg[ST_OUT];
    assign reflectance    = ctx_reg[ST_OUT].refl;
    assign total_internal = ctx_reg[ST_OUT].tir;

    // total internal reflection always reports full reflectance
    a_tir_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && total_internal |-> reflectance == REFL_ONE)
        else $error("tir word without full reflectance");

    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> reflectance <= REFL_ONE)
        else $error("reflectance above 1.0");

    // a stall freezes every valid bit
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> valid_reg == $past(valid_reg))
        else $error("pipeline moved during stall");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> valid_reg[ST_PROD])
        else $error("accepted word lost at entry");

endmodule

@@ sv/fr_sqrt_step.sv @@
module fr_sqrt_step
    import fr_pkg::*;
(
    input  sq_t sq_in,
    output sq_t sq_out
);

    always_comb
    begin
        sq_t         s;
        logic [34:0] trial;
        s = sq_in;
        for (int i = 0; i < SQRT_STEPS; i++)
        begin
            s.rem = {s.rem[32:0], s.rad[63:62]};
            s.rad = {s.rad[61:0], 2'b00};
            trial = {1'b0, s.root, 2'b01};
            if (s.rem >= trial)
            begin
                s.rem  = s.rem - trial;
                s.root = {s.root[30:0], 1'b1};
            end
            else
            begin
                s.root = {s.root[30:0], 1'b0};
            end
        end
        sq_out = s;
    end

endmodule

@@ sv/fr_div_step.sv @@
module fr_div_step
    import fr_pkg::*;
(
    input  dv_t dv_in,
    output dv_t dv_out
);

    always_comb
    begin
        dv_t         d;
        logic [32:0] t;
        d = dv_in;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            t      = {d.rem, d.feed[31]};
            d.feed = {d.feed[30:0], 1'b0};
            if (t >= {1'b0, d.den})
            begin
                d.rem = 32'(t - {1'b0, d.den});
                d.quo = {d.quo[30:0], 1'b1};
            end
            else
            begin
                d.rem = t[31:0];
                d.quo = {d.quo[30:0], 1'b0};
            end
        end
        dv_out = d;
    end

endmodule

@@ sv/fr_norm.sv @@
module fr_norm
    import fr_pkg::*;
(
    input  logic [47:0] num_in,
    input  logic [47:0] den_in,
    output logic [31:0] num_out,
    output logic [31:0] den_out
);

    logic [4:0]  sh;
    logic [47:0] num_sh;
    logic [47:0] den_sh;

    // shift so the denominator fits in 32 bits
    always_comb
    begin
        sh = 5'd0;
        for (int i = 0; i < 16; i++)
        begin
            if (den_in[32 + i])
            begin
                sh = 5'(i + 1);
            end
        end
    end

    assign num_sh  = num_in >> sh;
    assign den_sh  = den_in >> sh;
    assign num_out = num_sh[31:0];
    assign den_out = den_sh[31:0];

endmodule

@@ dv/fresnel_reflectance_tb.sv @@
module fresnel_reflectance_tb;
    import fr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 2 * NUM_STAGES + 10;

    typedef struct {
        logic signed [15:0] dx, dy, dz, nx, ny, nz;
        logic [15:0] eta;
    } ray_hit_t;

    typedef struct {
        logic [15:0] refl;
        logic        tir;
    } refl_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [15:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [15:0] dir_x = '0, dir_y = '0, dir_z = '0;
    logic signed [15:0] normal_x = '0, normal_y = '0, normal_z = '0;
    logic [15:0] object_index = 16'd4096;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [15:0] reflectance;
    logic total_internal;

    // predictor copy of the outer medium register
    logic [15:0] outer_index = CFG_RESET_INDEX;
    refl_word_t expected_refl[$];
    int errors = 0;
    int cycle_count = 0;
    bit hold_out = 1'b0;
    bit stall_mode = 1'b1;

    fresnel_reflectance dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog over the whole run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    // coefficient magnitude in Q.31, zero denominator means 1.0
    function automatic logic [63:0] coef_q31(logic [63:0] num, logic [63:0] den);
        while (den >= (64'd1 << 32))
        begin
            den >>= 1;
            num >>= 1;
        end
        if (den == 0) return 64'd1 << 31;
        if (num > den) num = den;
        return (num << 31) / den;
    endfunction

    function automatic refl_word_t fresnel_predict(ray_hit_t h);
        refl_word_t w;
        longint signed dot;
        logic [63:0] mag, ci, si, st, ct, rs, rp, kr, r, ei, et, a, b, t;
        dot = longint'(h.dx) * h.nx + longint'(h.dy) * h.ny + longint'(h.dz) * h.nz;
        mag = (dot < 0) ? 64'(-dot) : 64'(dot);
        if (mag > ONE_DOT) mag = ONE_DOT;
        ci = (mag >> DOT_SH_R) << DOT_SH_L;
        if (ci > ONE_Q30) ci = ONE_Q30;
        ei = outer_index;
        et = h.eta;
        if (dot > 0)
        begin
            t = ei;
            ei = et;
            et = t;
        end
        si = int_sqrt((ONE_Q30 - ((ci * ci) >> 30)) << 30);
        if (ei * si >= et * ONE_Q30)
        begin
            w.refl = REFL_ONE;
            w.tir = 1'b1;
            return w;
        end
        st = (ei * si) / et;
        ct = int_sqrt((ONE_Q30 - ((st * st) >> 30)) << 30);
        a = et * ci;
        b = ei * ct;
        rs = coef_q31(a > b ? a - b : b - a, a + b);
        a = ei * ci;
        b = et * ct;
        rp = coef_q31(a > b ? a - b : b - a, a + b);
        kr = (((rs * rs) >> 31) + ((rp * rp) >> 31)) >> 1;
        r = (kr + (64'd1 << 15)) >> 16;
        if (r > 32768) r = 32768;
        w.refl = r[15:0];
        w.tir = 1'b0;
        return w;
    endfunction

    // valid stays high after the accepting edge; the next call lowers it for a random gap, or drain does
    task automatic send_hit(ray_hit_t h);
        int gap;
        gap = stall_mode ? $urandom_range(0, 6) : 0;
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        dir_x <= h.dx;
        dir_y <= h.dy;
        dir_z <= h.dz;
        normal_x <= h.nx;
        normal_y <= h.ny;
        normal_z <= h.nz;
        object_index <= h.eta;
        do @(posedge clk); while (!in_ready);
        expected_refl.push_back(fresnel_predict(h));
    endtask

    // idle until every word is back, then let the pipeline settle
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_refl.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_outer(logic [15:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        outer_index = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [15:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'sd0;
            3: return 16'($urandom);
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    // random hit: mostly small components, otherwise a mix of axis, zero and random components
    function automatic ray_hit_t rand_hit();
        ray_hit_t h;
        int mode;
        mode = $urandom_range(0, 9);
        h.dx = rand_comp();
        h.dy = rand_comp();
        h.dz = rand_comp();
        h.nx = rand_comp();
        h.ny = rand_comp();
        h.nz = rand_comp();
        if (mode < 6)
        begin
            // near-physical: small components so the dot stays within one
            h.dx = 16'($signed($urandom_range(0, 18918)) - 9459);
            h.dy = 16'($signed($urandom_range(0, 18918)) - 9459);
            h.dz = 16'($signed($urandom_range(0, 18918)) - 9459);
            h.nx = 16'($signed($urandom_range(0, 18918)) - 9459);
            h.ny = 16'($signed($urandom_range(0, 18918)) - 9459);
            h.nz = 16'($signed($urandom_range(0, 18918)) - 9459);
        end
        case ($urandom_range(0, 4))
            0: h.eta = 16'($urandom);
            1: h.eta = 16'($urandom_range(0, 3));
            2: h.eta = 16'hFFFF;
            default: h.eta = 16'($urandom_range(4096, 12288));
        endcase
        return h;
    endfunction

    task automatic test_directed();
        ray_hit_t h;
        int k;
        // head-on hit from outside, air into glass
        h = '{16'sd0, 16'sd0, -16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 16'd6144};
        send_hit(h);
        // exiting hit, dot positive, indices swap
        h = '{16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 16'd6144};
        send_hit(h);
        // grazing hit, zero cosine
        h = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'd6144};
        send_hit(h);
        // oblique exit beyond the critical angle
        h = '{16'sd11585, 16'sd0, 16'sd11585, 16'sd0, 16'sd0, 16'sd16384, 16'd8192};
        send_hit(h);
        // non-unit vectors, dot clamped both ways
        h = '{-16'sd32768, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 16'sd32767,
              16'd4096};
        send_hit(h);
        h = '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768,
              16'd4096};
        send_hit(h);
        // zero transmitted-side index
        h = '{16'sd0, 16'sd0, -16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 16'd0};
        send_hit(h);
        // matched indices, zero reflectance
        h = '{16'sd0, 16'sd0, -16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 16'd4096};
        send_hit(h);
        // index extremes
        h = '{16'sd0, -16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'hFFFF};
        send_hit(h);
        h = '{16'sd0, -16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'd1};
        send_hit(h);
        for (k = 0; k < 8; k++) send_hit(rand_hit());
    endtask

    task automatic test_random(int count);
        for (int k = 0; k < count; k++) send_hit(rand_hit());
    endtask

    // receiver holds off for a long time while the sender keeps going
    task automatic test_backpressure();
        stall_mode = 1'b0;
        hold_out = 1'b1;
        fork
            begin
                repeat (3 * NUM_STAGES) @(negedge clk);
                hold_out = 1'b0;
            end
            test_random(4 * NUM_STAGES);
        join
        stall_mode = 1'b1;
    endtask

    task automatic test_config_sweep();
        // zero outer index swaps into a zero transmitted side when exiting
        write_outer(16'd0);
        test_random(60);
        write_outer(16'hFFFF);
        test_random(60);
        write_outer(16'd1);
        test_random(60);
        write_outer(16'd5461);
        test_random(150);
        write_outer(16'($urandom));
        test_random(150);
        write_outer(CFG_RESET_INDEX);
    endtask

    // output side: random stall per word, then check it
    initial
    begin
        refl_word_t w;
        int gap;
        forever
        begin
            gap = stall_mode ? $urandom_range(0, 6) : 0;
            @(negedge clk);
            if (gap != 0 || hold_out)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
                while (hold_out) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            if (expected_refl.size() == 0)
            begin
                $error("unexpected word: reflectance %0d total_internal %0d",
                       reflectance, total_internal);
                errors++;
            end
            else
            begin
                w = expected_refl.pop_front();
                if (reflectance !== w.refl)
                begin
                    $error("reflectance expected %0d actual %0d", w.refl, reflectance);
                    errors++;
                end
                if (total_internal !== w.tir)
                begin
                    $error("total_internal expected %0d actual %0d", w.tir, total_internal);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_backpressure();
        test_random(300);
        // a stretch with no gaps on either side
        stall_mode = 1'b0;
        test_random(150);
        stall_mode = 1'b1;
        test_config_sweep();
        test_random(200);
        drain();
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
